>>> src/set_associative_lru_cache_model_unit_assert.svh
// Assertion macros for the cache model unit.
// Used by the top level only; no dependencies.
`ifndef SET_ASSOCIATIVE_LRU_CACHE_MODEL_UNIT_ASSERT_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_MODEL_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SALC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SALC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SALC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SALC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/salc_pkg.sv
// Shared types and constants for the cache model unit.
// No dependencies.
package salc_pkg;
   localparam int MaxSetBits = 6;
   localparam int MaxWays = 8;
   localparam int StampBits = 32;
   localparam int Sets = 1 << MaxSetBits;
   localparam int WayBits = (MaxWays > 1) ? $clog2(MaxWays) : 1;
   localparam int WaysBits = $clog2(MaxWays + 1);
   localparam int SetIdxBits = (MaxSetBits > 0) ? MaxSetBits : 1;
   localparam int LineBits = 1 + 64 + StampBits;

   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OUT_HIT = 2'd0;
   localparam logic [1:0] OUT_FILL = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;
   localparam logic [1:0] REG_SET_BITS = 2'd0;
   localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [63:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0] outcome;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] eviction_total;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic [63:0] tag;
      logic [StampBits-1:0] stamp;
   } line_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic lookup;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } sts_type;
endpackage

>>> src/salc_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module salc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> src/salc_datapath.sv
// Datapath: set memories per way, tag compare, victim choice, counters.
// Depends on salc_pkg and salc_ram.
module salc_datapath (
   input  logic              clock,
   input  logic              reset,
   input  salc_pkg::cmd_type cmd,
   output salc_pkg::sts_type sts,
   input  salc_pkg::req_type req,
   input  logic [2:0]        set_bits,
   input  logic [4:0]        block_bits,
   input  logic [3:0]        ways,
   output salc_pkg::rsp_type rsp_data
);
   localparam int W = salc_pkg::MaxWays;
   localparam int SB = salc_pkg::StampBits;

   logic [1:0] op_ff;
   logic [63:0] tag_ff, tag_in;
   logic [salc_pkg::SetIdxBits-1:0] set_ff, set_in, clr_ff;
   logic [salc_pkg::WaysBits-1:0] e_ff, e_in;
   logic [SB-1:0] stamp_ff;
   logic [31:0] hit_ff, miss_ff, evict_ff;
   salc_pkg::rsp_type rsp_ff;
   salc_pkg::line_type rd [W];
   logic [W-1:0] we;
   logic [salc_pkg::SetIdxBits-1:0] wa;
   salc_pkg::line_type wd;
   logic [2:0] s_eff;
   logic [6:0] sh;
   logic [63:0] setmask;

   logic hit;
   logic [salc_pkg::WayBits-1:0] hit_way, inv_way, vic_way, sel_way;
   logic any_inv;
   logic [1:0] outcome;

   always_comb begin
      s_eff = (set_bits > 3'(salc_pkg::MaxSetBits)) ? 3'(salc_pkg::MaxSetBits) : set_bits;
      sh = 7'(block_bits) + 7'(s_eff);
      setmask = (64'd1 << s_eff) - 64'd1;
      set_in = salc_pkg::SetIdxBits'((req.address >> block_bits) & setmask);
      tag_in = req.address >> sh;
      if (ways == 4'd0) e_in = salc_pkg::WaysBits'(1);
      else if (ways > 4'(W)) e_in = salc_pkg::WaysBits'(W);
      else e_in = salc_pkg::WaysBits'(ways);
   end

   always_comb begin
      hit = 1'b0;
      hit_way = '0;
      any_inv = 1'b0;
      inv_way = '0;
      vic_way = '0;
      for (int w = W - 1; w >= 0; w--) begin
         if (w < int'(e_ff)) begin
            if (rd[w].valid && rd[w].tag == tag_ff) begin
               hit = 1'b1;
               hit_way = salc_pkg::WayBits'(w);
            end
            if (!rd[w].valid) begin
               any_inv = 1'b1;
               inv_way = salc_pkg::WayBits'(w);
            end
         end
      end
      for (int w = 1; w < W; w++) begin
         if (w < int'(e_ff) && rd[w].stamp < rd[vic_way].stamp) begin
            vic_way = salc_pkg::WayBits'(w);
         end
      end
      if (hit) begin
         sel_way = hit_way;
         outcome = salc_pkg::OUT_HIT;
      end else if (any_inv) begin
         sel_way = inv_way;
         outcome = salc_pkg::OUT_FILL;
      end else begin
         sel_way = vic_way;
         outcome = salc_pkg::OUT_EVICT;
      end
   end

   function automatic logic [31:0] sat(input logic [31:0] v, input logic inc);
      return (inc && v != '1) ? v + 32'd1 : v;
   endfunction

   logic [31:0] hit_pre, hit_in, miss_in, evict_in;
   always_comb begin
      hit_pre = sat(hit_ff, op_ff == salc_pkg::OP_MODIFY);
      hit_in = sat(hit_pre, hit);
      miss_in = sat(miss_ff, !hit);
      evict_in = sat(evict_ff, outcome == salc_pkg::OUT_EVICT);
      we = '0;
      if (cmd.clear) begin
         we = '1;
         wa = clr_ff;
         wd = '0;
      end else begin
         wa = set_ff;
         wd.valid = 1'b1;
         wd.tag = tag_ff;
         wd.stamp = stamp_ff;
         if (cmd.commit) we[sel_way] = 1'b1;
      end
   end

   for (genvar g = 0; g < W; g++) begin : g_way
      salc_ram #(.Width(salc_pkg::LineBits), .Depth(salc_pkg::Sets)) u_ram (
         .clock(clock), .wr_en(we[g]), .wr_addr(wa), .wr_data(wd),
         .rd_addr(cmd.load ? set_in : set_ff), .rd_data(rd[g]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         stamp_ff <= SB'(1);
         hit_ff <= '0;
         miss_ff <= '0;
         evict_ff <= '0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.commit) begin
            stamp_ff <= stamp_ff + 1'b1;
            hit_ff <= hit_in;
            miss_ff <= miss_in;
            evict_ff <= evict_in;
         end
      end
      if (cmd.load) begin
         op_ff <= req.operation;
         tag_ff <= tag_in;
         set_ff <= set_in;
         e_ff <= e_in;
      end
      if (cmd.commit) begin
         rsp_ff.outcome <= outcome;
         rsp_ff.hit_total <= hit_in;
         rsp_ff.miss_total <= miss_in;
         rsp_ff.eviction_total <= evict_in;
      end
   end

   assign sts.clear_done = (clr_ff == '1);
   assign rsp_data = rsp_ff;
endmodule

>>> src/salc_control.sv
// Controller: clearing pass after reset, then load, lookup, commit per transfer.
// Depends on salc_pkg.
module salc_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output salc_pkg::cmd_type cmd,
   input  salc_pkg::sts_type sts
);
   typedef enum logic [1:0] {CLEAR, IDLE, LOOKUP} state_type;
   state_type state_ff;
   logic done_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         CLEAR: cmd.clear = 1'b1;
         IDLE: cmd.load = start;
         LOOKUP: cmd.commit = 1'b1;
         default: cmd = '0;
      endcase
   end
   assign busy = (state_ff != IDLE);
   assign rsp_valid = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (state_ff == LOOKUP);
         unique case (state_ff)
            CLEAR: if (sts.clear_done) state_ff <= IDLE;
            IDLE: if (start) state_ff <= LOOKUP;
            LOOKUP: state_ff <= IDLE;
            default: state_ff <= CLEAR;
         endcase
      end
   end
endmodule

>>> src/set_associative_lru_cache_model_unit.sv
// Top level of the set-associative LRU cache model unit.
// Depends on salc_pkg, salc_control, salc_datapath and the assertion header.
//
//  channel  | handshake                    | payload
//  req      | start / busy                 | req_payload (operation, address)
//  rsp      | rsp_valid strobe, one cycle  | rsp_payload (outcome, totals)
//  csr      | APB write/read, pready high  | set_bits, block_bits, ways
//
// An access does a set read, then compare and write-back of the
// way memories; the result strobes in the cycle after. A new start is taken
// as the result shows. After reset a clearing pass over every set runs (one set
// per cycle) with busy high. The receiver cannot stall.
`include "set_associative_lru_cache_model_unit_assert.svh"
module set_associative_lru_cache_model_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  salc_pkg::req_type req_payload,
   output logic              rsp_valid,
   output salc_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   logic [2:0] set_bits_ff;
   logic [4:0] block_bits_ff;
   logic [3:0] ways_ff;
   salc_pkg::cmd_type cmd;
   salc_pkg::sts_type sts;
   logic wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= 3'd0;
         block_bits_ff <= 5'd4;
         ways_ff <= 4'd1;
      end else if (wr && paddr[1:0] == 2'b00) begin
         unique case (paddr[3:2])
            salc_pkg::REG_SET_BITS: set_bits_ff <= pwdata[2:0];
            salc_pkg::REG_BLOCK_BITS: block_bits_ff <= pwdata[4:0];
            salc_pkg::REG_WAYS: ways_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         salc_pkg::REG_SET_BITS: prdata = {29'd0, set_bits_ff};
         salc_pkg::REG_BLOCK_BITS: prdata = {27'd0, block_bits_ff};
         salc_pkg::REG_WAYS: prdata = {28'd0, ways_ff};
         default: prdata = '0;
      endcase
   end

   salc_control u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_valid(rsp_valid), .cmd(cmd), .sts(sts));

   salc_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req(req_payload),
      .set_bits(set_bits_ff), .block_bits(block_bits_ff), .ways(ways_ff),
      .rsp_data(rsp_payload));

   `SALC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SALC_ASSERT_NEXT(a_accept_rsp, clock, reset, start && !busy, ##1 rsp_valid)
   `SALC_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `SALC_ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))
endmodule
